// ===== design/mcpg_pkg.sv =====
// Package: widths, step record and queue status types for the circle point generator.
package mcpg_pkg;

   // Coordinate width of center and radius
   localparam int COORD_BITS = 10;
   // Offset, point and decision widths follow from it
   localparam int OFF_BITS = COORD_BITS + 1;
   localparam int PT_BITS  = COORD_BITS + 2;
   localparam int DEC_BITS = COORD_BITS + 4;

   // Step queue depth
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   // Points per step and point index width
   localparam int PTS_PER_STEP = 8;
   localparam int IDX_BITS     = $clog2(PTS_PER_STEP);

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // One step: center and offsets to expand into eight points
   typedef struct packed {
      logic [COORD_BITS-1:0]      center_x;
      logic [COORD_BITS-1:0]      center_y;
      logic signed [OFF_BITS-1:0] offset_x;
      logic signed [OFF_BITS-1:0] offset_y;
      logic                       done;
   } step_rec_type;

   // Queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic nonempty;
   } q_status_type;

endpackage

// ===== design/mcpg_req_if.sv =====
// Request channel interface: command, center and radius.
interface mcpg_req_if;
   import mcpg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-1:0] radius;

   modport source (output valid, output cmd, output center_x, output center_y,
                   output radius, input ready);
   modport sink   (input valid, input cmd, input center_x, input center_y,
                   input radius, output ready);
endinterface

// ===== design/mcpg_rsp_if.sv =====
// Response channel interface: one circle point per transfer.
interface mcpg_rsp_if;
   import mcpg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [PT_BITS-1:0] point_x;
   logic signed [PT_BITS-1:0] point_y;
   logic                      last_point;
   logic                      circle_done;

   modport source (output valid, output point_x, output point_y,
                   output last_point, output circle_done, input ready);
   modport sink   (input valid, input point_x, input point_y,
                   input last_point, input circle_done, output ready);
endinterface

// ===== design/mcpg_front.sv =====
// Front part: accepts requests, runs the midpoint decision update, queues step records.
module mcpg_front (
   input  logic                  clock,
   input  logic                  reset,
   mcpg_req_if.sink              req,
   input  mcpg_pkg::q_status_type q_status,
   output logic                  push,
   output mcpg_pkg::step_rec_type push_rec
);
   import mcpg_pkg::*;

   logic [COORD_BITS-1:0]      cx_ff, cx_in;
   logic [COORD_BITS-1:0]      cy_ff, cy_in;
   logic signed [OFF_BITS-1:0] x_ff, x_in;
   logic signed [OFF_BITS-1:0] y_ff, y_in;
   logic signed [DEC_BITS-1:0] dec_ff, dec_in;
   logic                       active_ff, active_in;

   logic                       req_take;
   logic signed [OFF_BITS-1:0] nx, ny;
   logic signed [DEC_BITS-1:0] nx_ext, y_ext, r2_ext;
   logic                       step_done;

   // Any request waits only on queue space
   assign req.ready = !q_status.full;
   assign req_take  = req.valid && req.ready;

   // Next offsets and done flag for a step
   always_comb begin
      nx     = x_ff + OFF_BITS'(1);
      nx_ext = DEC_BITS'(nx);
      y_ext  = DEC_BITS'(y_ff);
      r2_ext = DEC_BITS'({req.radius, 1'b0});
      if (dec_ff[DEC_BITS-1]) begin
         ny = y_ff;
      end else begin
         ny = y_ff - OFF_BITS'(1);
      end
      step_done = nx > ny;
   end

   // State update per accepted request
   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      active_in = active_ff;
      if (req_take) begin
         case (req.cmd)
            CMD_START: begin
               cx_in     = req.center_x;
               cy_in     = req.center_y;
               x_in      = '0;
               y_in      = OFF_BITS'(req.radius);
               dec_in    = DEC_BITS'(3) - r2_ext;
               active_in = 1'b1;
            end
            CMD_STEP: begin
               if (active_ff) begin
                  x_in = nx;
                  y_in = ny;
                  if (dec_ff[DEC_BITS-1]) begin
                     dec_in = dec_ff + (nx_ext <<< 2) + DEC_BITS'(6);
                  end else begin
                     dec_in = dec_ff + ((nx_ext - y_ext) <<< 2) + DEC_BITS'(10);
                  end
                  if (step_done) begin
                     active_in = 1'b0;
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // Record of the step taken: offsets before the update
   assign push              = req_take && (req.cmd == CMD_STEP) && active_ff;
   assign push_rec.center_x = cx_ff;
   assign push_rec.center_y = cy_ff;
   assign push_rec.offset_x = x_ff;
   assign push_rec.offset_y = y_ff;
   assign push_rec.done     = step_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         dec_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         dec_ff    <= dec_in;
         active_ff <= active_in;
      end
   end

   // A finished run accepts no further step record
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      push && push_rec.done |=> !active_ff || $past(req.cmd) == CMD_START)
      else $error("active still set after final step");
   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full step queue");
   a_offsets_ordered: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> x_ff <= y_ff)
      else $error("active run with x beyond y");

endmodule

// ===== design/mcpg_queue.sv =====
// Step queue: short FIFO of step records between the front and back parts.
module mcpg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mcpg_pkg::step_rec_type push_rec,
   input  logic                   pop,
   output mcpg_pkg::step_rec_type pop_rec,
   output mcpg_pkg::q_status_type status
);
   import mcpg_pkg::*;

   step_rec_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]     count_ff, count_in;
   logic                      do_pop;

   assign status.full     = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign status.nonempty = (count_ff != '0);
   assign pop_rec         = entry_ff[rd_ptr_ff];
   assign do_pop          = pop && status.nonempty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + Q_PTR_BITS'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + Q_CNT_BITS'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_BITS'(Q_DEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && status.full |-> do_pop)
      else $error("push into full queue");
   a_ptrs_match_empty: assert property (@(posedge clock) disable iff (reset)
      !status.nonempty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");

endmodule

// ===== design/mcpg_back.sv =====
// Back part: expands each step record into eight symmetric points, one per cycle while rsp is ready.
module mcpg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mcpg_pkg::step_rec_type pop_rec,
   input  mcpg_pkg::q_status_type q_status,
   output logic                   pop,
   mcpg_rsp_if.source             rsp
);
   import mcpg_pkg::*;

   step_rec_type              rec_ff, rec_in;
   logic                      busy_ff, busy_in;
   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [PT_BITS-1:0] px_ff, px_in;
   logic signed [PT_BITS-1:0] py_ff, py_in;
   logic                      last_ff, last_in;
   logic                      done_ff, done_in;

   logic                      out_adv;
   logic                      emit_last;
   logic signed [PT_BITS-1:0] cx_ext, cy_ext, a_ext, b_ext;

   assign out_adv   = !out_valid_ff || rsp.ready;
   assign emit_last = busy_ff && out_adv && (idx_ff == IDX_BITS'(PTS_PER_STEP - 1));
   assign pop       = q_status.nonempty && (!busy_ff || emit_last);

   // Point selection: bit 2 swaps x and y, bit 1 negates x term, bit 0 negates y term
   always_comb begin
      cx_ext = PT_BITS'(rec_ff.center_x);
      cy_ext = PT_BITS'(rec_ff.center_y);
      if (idx_ff[2]) begin
         a_ext = PT_BITS'(rec_ff.offset_y);
         b_ext = PT_BITS'(rec_ff.offset_x);
      end else begin
         a_ext = PT_BITS'(rec_ff.offset_x);
         b_ext = PT_BITS'(rec_ff.offset_y);
      end
   end

   // Sequencer and output register
   always_comb begin
      rec_in       = rec_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (out_adv) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            px_in   = idx_ff[1] ? cx_ext - a_ext : cx_ext + a_ext;
            py_in   = idx_ff[0] ? cy_ext - b_ext : cy_ext + b_ext;
            last_in = emit_last;
            done_in = emit_last && rec_ff.done;
            idx_in  = emit_last ? '0 : idx_ff + IDX_BITS'(1);
            if (emit_last) begin
               busy_in = 1'b0;
            end
         end
      end
      if (pop) begin
         rec_in  = pop_rec;
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.point_x     = px_ff;
   assign rsp.point_y     = py_ff;
   assign rsp.last_point  = last_ff;
   assign rsp.circle_done = done_ff;

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.circle_done |-> rsp.last_point)
      else $error("circle_done without last_point");
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> idx_ff == '0)
      else $error("point index nonzero while idle");
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.nonempty)
      else $error("pop from empty queue");

endmodule

// ===== design/midpoint_circle_point_generator.sv =====
// Top level: midpoint circle point generator with eight-way symmetry.
//
//  channel  dir  transfer  payload
//  req_ch   in   request   cmd, center_x, center_y, radius
//  rsp_ch   out  point     point_x, point_y, last_point, circle_done
//
// A start request emits no points; a step request passes through the front part and
// emits eight points, one per cycle while rsp_ch is ready, from the back part.
// Sustained step throughput is set by the single point output register.
// The two-entry step queue lets requests be accepted while points drain.
// Reset is synchronous, active high, and clears the run state and the queue.
// A stalled rsp_ch holds its point; req_ch stalls only while the queue is full.
module midpoint_circle_point_generator (
   input  logic      clock,
   input  logic      reset,
   mcpg_req_if.sink   req_ch,
   mcpg_rsp_if.source rsp_ch
);
   import mcpg_pkg::*;

   logic         push;
   step_rec_type push_rec;
   logic         pop;
   step_rec_type pop_rec;
   q_status_type q_status;

   mcpg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_rec (push_rec)
   );

   mcpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .status   (q_status)
   );

   mcpg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_rec  (pop_rec),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule
